// ----- hw/rtl/bsa_pkg.sv -----
// Shared types, opcode field codes and operand select decode for the
// 4-bit slice ALU. No dependencies.
package bsa_pkg;

  localparam int unsigned NibW   = 4;
  localparam int unsigned OpW    = 9;
  localparam int unsigned RegCnt = 16;
  localparam int unsigned AddrW  = $clog2(RegCnt);

  // Source pair field, opcode bits 2..0
  typedef enum logic [2:0] {
    SRC_AQ = 3'd0,
    SRC_AB = 3'd1,
    SRC_ZQ = 3'd2,
    SRC_ZB = 3'd3,
    SRC_ZA = 3'd4,
    SRC_DA = 3'd5,
    SRC_DQ = 3'd6,
    SRC_DZ = 3'd7
  } src_t;

  // Function field, opcode bits 5..3
  typedef enum logic [2:0] {
    FN_ADD  = 3'd0,
    FN_SUBR = 3'd1,
    FN_SUBS = 3'd2,
    FN_OR   = 3'd3,
    FN_AND  = 3'd4,
    FN_NOTRS = 3'd5,
    FN_EXOR = 3'd6,
    FN_EXNOR = 3'd7
  } fn_t;

  // Destination field, opcode bits 8..6
  typedef enum logic [2:0] {
    DST_QREG  = 3'd0,
    DST_NOP   = 3'd1,
    DST_RAMA  = 3'd2,
    DST_RAMF  = 3'd3,
    DST_RAMQD = 3'd4,
    DST_RAMD  = 3'd5,
    DST_RAMQU = 3'd6,
    DST_RAMU  = 3'd7
  } dst_t;

  // R operand source
  typedef enum logic [1:0] {
    RSEL_ZERO = 2'd0,
    RSEL_A    = 2'd1,
    RSEL_D    = 2'd2
  } rsel_t;

  // S operand source
  typedef enum logic [1:0] {
    SSEL_ZERO = 2'd0,
    SSEL_A    = 2'd1,
    SSEL_B    = 2'd2,
    SSEL_Q    = 2'd3
  } ssel_t;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [AddrW-1:0] addr_a;
    logic [AddrW-1:0] addr_b;
    logic [NibW-1:0]  data_in;
    logic             carry_in;
    logic             ram_lsb_in;
    logic             ram_msb_in;
    logic             q_lsb_in;
    logic             q_msb_in;
  } req_t;

  typedef struct packed {
    logic [NibW-1:0] y_out;
    logic            carry_out;
    logic            overflow;
    logic            propagate_n;
    logic            generate_n;
    logic            zero_flag;
    logic            sign_flag;
    logic            ram_lsb_out;
    logic            ram_msb_out;
    logic            q_lsb_out;
    logic            q_msb_out;
  } rsp_t;

  // Write-back controls from the ALU to the state holders
  typedef struct packed {
    logic            ram_we;
    logic [NibW-1:0] ram_data;
    logic            q_we;
    logic [NibW-1:0] q_data;
  } wb_t;

  function automatic rsel_t rsel_of(input src_t src);
    rsel_t sel;
    unique case (src)
      SRC_AQ, SRC_AB:         sel = RSEL_A;
      SRC_ZQ, SRC_ZB, SRC_ZA: sel = RSEL_ZERO;
      default:                sel = RSEL_D;
    endcase
    return sel;
  endfunction

  function automatic ssel_t ssel_of(input src_t src);
    ssel_t sel;
    unique case (src)
      SRC_AQ, SRC_ZQ, SRC_DQ: sel = SSEL_Q;
      SRC_AB, SRC_ZB:         sel = SSEL_B;
      SRC_ZA, SRC_DA:         sel = SSEL_A;
      default:                sel = SSEL_ZERO;
    endcase
    return sel;
  endfunction

endpackage

// ----- hw/rtl/bsa_if.sv -----
// Valid/ready channel interfaces for the slice ALU requests and results.
// Depends on bsa_pkg.
interface bsa_req_if;
  import bsa_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bsa_rsp_if;
  import bsa_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/bsa_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module bsa_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr0,
  input  logic [$clog2(Depth)-1:0] raddr1,
  output logic [Width-1:0]         rdata0,
  output logic [Width-1:0]         rdata1
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports return the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// ----- hw/rtl/bsa_alu.sv -----
// Operand select, 8-function ALU with lookahead flags, and destination
// decode for the slice. Combinational. Depends on bsa_pkg.
module bsa_alu (
  input  bsa_pkg::req_t          req,
  input  logic [bsa_pkg::NibW-1:0] a,
  input  logic [bsa_pkg::NibW-1:0] b,
  input  logic [bsa_pkg::NibW-1:0] q,
  output bsa_pkg::rsp_t          rsp,
  output bsa_pkg::wb_t           wb
);
  import bsa_pkg::*;

  src_t            src;
  fn_t             fn;
  dst_t            dst;
  logic [NibW-1:0] r, s, rr, ss, p, g, f;
  logic [NibW:0]   sum;
  logic [NibW-1:0] sum_lo;
  logic            c;
  logic            pall, gany, glook;
  logic            co, ovr, pn, gn;
  logic            lo, hi;

  assign src = src_t'(req.opcode[2:0]);
  assign fn  = fn_t'(req.opcode[5:3]);
  assign dst = dst_t'(req.opcode[8:6]);
  assign c   = req.carry_in;

  // Operand select
  always_comb begin
    unique case (rsel_of(src))
      RSEL_A:  r = a;
      RSEL_D:  r = req.data_in;
      default: r = '0;
    endcase
    unique case (ssel_of(src))
      SSEL_A:  s = a;
      SSEL_B:  s = b;
      SSEL_Q:  s = q;
      default: s = '0;
    endcase
  end

  // Operand inversion for subtract and the inverted-R logic functions
  always_comb begin
    rr = r;
    ss = s;
    if (fn == FN_SUBR || fn == FN_NOTRS || fn == FN_EXOR) begin
      rr = ~r;
    end else if (fn == FN_SUBS) begin
      ss = ~s;
    end
  end

  assign p      = rr | ss;
  assign g      = rr & ss;
  assign pall   = &p;
  assign gany   = |g;
  assign glook  = g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1]);
  assign sum    = {1'b0, rr} + {1'b0, ss} + {{NibW{1'b0}}, c};
  assign sum_lo = {1'b0, rr[2:0]} + {1'b0, ss[2:0]} + {{(NibW-1){1'b0}}, c};

  // Overflow terms of the exclusive functions
  assign lo = ~p[2] | (~g[2] & ~p[1]) | (~g[2] & ~g[1] & ~p[0])
            | (~g[2] & ~g[1] & ~g[0] & c);
  assign hi = ~p[3] | (~g[3] & ~p[2]) | (~g[3] & ~g[2] & ~p[1])
            | (~g[3] & ~g[2] & ~g[1] & ~p[0])
            | (~g[3] & ~g[2] & ~g[1] & ~g[0] & c);

  // Function result and flags
  always_comb begin
    unique case (fn)
      FN_ADD, FN_SUBR, FN_SUBS: begin
        f   = sum[NibW-1:0];
        co  = sum[NibW];
        ovr = sum_lo[NibW-1] ^ sum[NibW];
        pn  = ~pall;
        gn  = ~(glook | (p[3] & p[2] & p[1] & g[0]));
      end
      FN_OR: begin
        f   = p;
        pn  = 1'b0;
        gn  = pall;
        co  = ~pall | c;
        ovr = ~pall | c;
      end
      FN_AND, FN_NOTRS: begin
        f   = g;
        pn  = 1'b0;
        gn  = ~gany;
        co  = gany | c;
        ovr = gany | c;
      end
      default: begin
        f   = g | ~p;
        pn  = gany;
        gn  = glook | pall;
        co  = ~(glook | (pall & (g[0] | ~c)));
        ovr = lo ^ hi;
      end
    endcase
  end

  // Destination decode: write-back, result fields and shift ports
  always_comb begin
    wb              = '0;
    rsp             = '0;
    rsp.y_out       = (dst == DST_RAMA) ? a : f;
    rsp.carry_out   = co;
    rsp.overflow    = ovr;
    rsp.propagate_n = pn;
    rsp.generate_n  = gn;
    rsp.zero_flag   = (f == '0);
    rsp.sign_flag   = f[3];
    unique case (dst)
      DST_QREG: begin
        wb.q_we   = 1'b1;
        wb.q_data = f;
      end
      DST_NOP: begin
      end
      DST_RAMA, DST_RAMF: begin
        wb.ram_we   = 1'b1;
        wb.ram_data = f;
      end
      DST_RAMQD, DST_RAMD: begin
        wb.ram_we       = 1'b1;
        wb.ram_data     = {req.ram_msb_in, f[3:1]};
        rsp.ram_lsb_out = f[0];
        rsp.q_lsb_out   = q[0];
        if (dst == DST_RAMQD) begin
          wb.q_we   = 1'b1;
          wb.q_data = {req.q_msb_in, q[3:1]};
        end
      end
      default: begin
        wb.ram_we       = 1'b1;
        wb.ram_data     = {f[2:0], req.ram_lsb_in};
        rsp.ram_msb_out = f[3];
        rsp.q_msb_out   = q[3];
        if (dst == DST_RAMQU) begin
          wb.q_we   = 1'b1;
          wb.q_data = {q[2:0], req.q_lsb_in};
        end
      end
    endcase
  end

endmodule

// ----- hw/rtl/four_bit_slice_alu_with_regfile.sv -----
// Top level of the 4-bit slice ALU with 16-entry register file and Q.
// Each accepted request: RAM read and request capture on the accept edge,
// then execute and write back into the output register when the execute
// stage advances, held while a result waits untaken. Throughput: 1 request
// per cycle while results are taken, set by the single execute stage around
// the RAM read port. Reset: synchronous; register file entries and Q read as
// zero afterwards, no clearing pass. Depends on bsa_pkg, bsa_if, bsa_ram, bsa_alu.
module four_bit_slice_alu_with_regfile (
  input logic    clk,
  input logic    rst,
  bsa_req_if.sink   req,
  bsa_rsp_if.source rsp
);
  import bsa_pkg::*;

  logic              req_fire;
  logic              s1_valid;
  logic              s1_adv;
  req_t              s1_req;
  logic [NibW-1:0]   rd_a, rd_b;
  logic              rd_va, rd_vb;
  logic [RegCnt-1:0] entry_valid;
  logic              byp_valid;
  logic [AddrW-1:0]  byp_addr;
  logic [NibW-1:0]   byp_data;
  logic [NibW-1:0]   a, b;
  logic [NibW-1:0]   q;
  rsp_t              alu_rsp;
  wb_t               wb;
  logic              ram_we;
  logic              q_we;
  logic              rsp_valid;
  rsp_t              rsp_data;

  // Handshake and stage advance
  assign s1_adv    = !rsp_valid || rsp.ready;
  assign req.ready = !s1_valid || s1_adv;
  assign req_fire  = req.valid && req.ready;
  assign ram_we    = s1_valid && s1_adv && wb.ram_we;
  assign q_we      = s1_valid && s1_adv && wb.q_we;

  bsa_ram #(
    .Width (NibW),
    .Depth (RegCnt)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (s1_req.addr_b),
    .wdata  (wb.ram_data),
    .re     (req_fire),
    .raddr0 (req.data.addr_a),
    .raddr1 (req.data.addr_b),
    .rdata0 (rd_a),
    .rdata1 (rd_b)
  );

  // Execute stage request, entry-valid snapshot and write forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      byp_valid <= 1'b0;
    end else begin
      if (req_fire) begin
        s1_valid  <= 1'b1;
        byp_valid <= ram_we;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
    if (req_fire) begin
      s1_req   <= req.data;
      rd_va    <= entry_valid[req.data.addr_a];
      rd_vb    <= entry_valid[req.data.addr_b];
      byp_addr <= s1_req.addr_b;
      byp_data <= wb.ram_data;
    end
  end

  // Entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[s1_req.addr_b] <= 1'b1;
    end
  end

  // Operand fixup: write landing on the read edge wins over RAM data
  always_comb begin
    if (byp_valid && byp_addr == s1_req.addr_a) begin
      a = byp_data;
    end else begin
      a = rd_va ? rd_a : '0;
    end
    if (byp_valid && byp_addr == s1_req.addr_b) begin
      b = byp_data;
    end else begin
      b = rd_vb ? rd_b : '0;
    end
  end

  bsa_alu u_alu (
    .req (s1_req),
    .a   (a),
    .b   (b),
    .q   (q),
    .rsp (alu_rsp),
    .wb  (wb)
  );

  // Q register
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (q_we) begin
      q <= wb.q_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= s1_valid;
    end
    if (s1_adv && s1_valid) begin
      rsp_data <= alu_rsp;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // Checks
  a_we_only_on_adv: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> s1_valid && s1_adv)
    else $error("register file written without an executing request");

  a_entry_marked: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> entry_valid[$past(s1_req.addr_b)])
    else $error("written entry not marked valid");

  a_q_hold: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && s1_adv) |=> $stable(q))
    else $error("Q changed without an executing request");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> req.ready)
    else $error("request stalled with empty execute stage");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for four_bit_slice_alu_with_regfile: directed and random microinstructions,
// each result checked against an in-bench model of the slice, register file and Q.
// Depends on bsa_pkg, bsa_if and the block's RTL.
module tb_top;
  import bsa_pkg::*;

  localparam int unsigned RandCnt   = 1150;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned MaxWait   = 13;
  localparam int unsigned ReportMax = 10;
  localparam int unsigned DrainCyc  = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bsa_req_if req_ch ();
  bsa_rsp_if rsp_ch ();

  four_bit_slice_alu_with_regfile dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #1 clk = ~clk;

  // model state
  logic [NibW-1:0] regfile_mdl [RegCnt];
  logic [NibW-1:0] q_mdl;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];

  int unsigned reqs_acc = 0;
  int unsigned rsps_acc = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic req_taken = 1'b0;
  logic rsp_taken = 1'b0;

  // one microinstruction of the slice: returns its outputs and updates the model state
  function automatic rsp_t slice_predict(input req_t rq);
    src_t src;
    fn_t fn;
    dst_t dst;
    logic [NibW-1:0] a, b, q, r, s, f, p, g, np, ng;
    logic [NibW:0] sum;
    logic [3:0] low3;
    logic cin, co, ovr, pn, gn, pall, gany, lo, hi;
    rsp_t res;
    src = src_t'(rq.opcode[2:0]);
    fn  = fn_t'(rq.opcode[5:3]);
    dst = dst_t'(rq.opcode[8:6]);
    a   = regfile_mdl[rq.addr_a];
    b   = regfile_mdl[rq.addr_b];
    q   = q_mdl;
    cin = rq.carry_in;

    // operand pair
    case (src)
      SRC_AQ, SRC_AB: r = a;
      SRC_ZQ, SRC_ZB, SRC_ZA: r = '0;
      default: r = rq.data_in;
    endcase
    case (src)
      SRC_AQ, SRC_ZQ, SRC_DQ: s = q;
      SRC_AB, SRC_ZB: s = b;
      SRC_ZA, SRC_DA: s = a;
      default: s = '0;
    endcase

    // functions that work on a complemented operand
    case (fn)
      FN_SUBR, FN_NOTRS, FN_EXOR: r = ~r;
      FN_SUBS: s = ~s;
      default: ;
    endcase

    p    = r | s;
    g    = r & s;
    np   = ~p;
    ng   = ~g;
    pall = &p;
    gany = |g;

    case (fn)
      FN_ADD, FN_SUBR, FN_SUBS: begin
        sum  = {1'b0, r} + {1'b0, s} + {4'b0, cin};
        low3 = {1'b0, r[2:0]} + {1'b0, s[2:0]} + {3'b0, cin};
        f    = sum[3:0];
        co   = sum[4];
        ovr  = low3[3] ^ sum[4];
        pn   = ~pall;
        gn   = ~(g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1]) | (p[3] & p[2] & p[1] & g[0]));
      end
      FN_OR: begin
        f   = p;
        pn  = 1'b0;
        gn  = pall;
        co  = ~pall | cin;
        ovr = co;
      end
      FN_AND, FN_NOTRS: begin
        f   = g;
        pn  = 1'b0;
        gn  = ~gany;
        co  = gany | cin;
        ovr = co;
      end
      default: begin
        // xor / xnor: lookahead terms from the complemented P and G
        f   = g | np;
        pn  = gany;
        gn  = g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1]) | pall;
        co  = ~(g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1]) | (pall & (g[0] | ~cin)));
        lo  = np[2] | (ng[2] & np[1]) | (ng[2] & ng[1] & np[0]) | (ng[2] & ng[1] & ng[0] & cin);
        hi  = np[3] | (ng[3] & np[2]) | (ng[3] & ng[2] & np[1])
            | (ng[3] & ng[2] & ng[1] & np[0]) | (ng[3] & ng[2] & ng[1] & ng[0] & cin);
        ovr = lo ^ hi;
      end
    endcase

    res             = '0;
    res.y_out       = (dst == DST_RAMA) ? a : f;
    res.carry_out   = co;
    res.overflow    = ovr;
    res.propagate_n = pn;
    res.generate_n  = gn;
    res.zero_flag   = (f == '0);
    res.sign_flag   = f[3];

    // write-back; every read above saw the old state
    case (dst)
      DST_QREG: q_mdl = f;
      DST_RAMA, DST_RAMF: regfile_mdl[rq.addr_b] = f;
      DST_RAMQD, DST_RAMD: begin
        regfile_mdl[rq.addr_b] = {rq.ram_msb_in, f[3:1]};
        res.ram_lsb_out = f[0];
        res.q_lsb_out   = q[0];
        if (dst == DST_RAMQD) q_mdl = {rq.q_msb_in, q[3:1]};
      end
      DST_RAMQU, DST_RAMU: begin
        regfile_mdl[rq.addr_b] = {f[2:0], rq.ram_lsb_in};
        res.ram_msb_out = f[3];
        res.q_msb_out   = q[3];
        if (dst == DST_RAMQU) q_mdl = {q[2:0], rq.q_lsb_in};
      end
      default: ;
    endcase
    return res;
  endfunction

  // names of the fields that differ, empty on a match
  function automatic string field_diff(input rsp_t w, input rsp_t g);
    string s;
    s = "";
    if (w.y_out !== g.y_out) s = {s, " y_out"};
    if (w.carry_out !== g.carry_out) s = {s, " carry_out"};
    if (w.overflow !== g.overflow) s = {s, " overflow"};
    if (w.propagate_n !== g.propagate_n) s = {s, " propagate_n"};
    if (w.generate_n !== g.generate_n) s = {s, " generate_n"};
    if (w.zero_flag !== g.zero_flag) s = {s, " zero_flag"};
    if (w.sign_flag !== g.sign_flag) s = {s, " sign_flag"};
    if (w.ram_lsb_out !== g.ram_lsb_out) s = {s, " ram_lsb_out"};
    if (w.ram_msb_out !== g.ram_msb_out) s = {s, " ram_msb_out"};
    if (w.q_lsb_out !== g.q_lsb_out) s = {s, " q_lsb_out"};
    if (w.q_msb_out !== g.q_msb_out) s = {s, " q_msb_out"};
    return s;
  endfunction

  // shift-in bits packed as {ram_lsb_in, ram_msb_in, q_lsb_in, q_msb_in}
  function automatic req_t make_req(input dst_t d, input fn_t f, input src_t s,
                                    input logic [3:0] aa, input logic [3:0] ab,
                                    input logic [3:0] dd, input logic c,
                                    input logic [3:0] sh);
    req_t rq;
    rq.opcode     = {d, f, s};
    rq.addr_a     = aa;
    rq.addr_b     = ab;
    rq.data_in    = dd;
    rq.carry_in   = c;
    rq.ram_lsb_in = sh[3];
    rq.ram_msb_in = sh[2];
    rq.q_lsb_in   = sh[1];
    rq.q_msb_in   = sh[0];
    return rq;
  endfunction

  // mostly a few hot registers so reads see earlier writes
  function automatic req_t rand_req();
    logic [$bits(req_t)-1:0] raw;
    req_t rq;
    raw = $bits(req_t)'($urandom);
    rq  = raw;
    if ($urandom_range(0, 9) < 7) begin
      rq.addr_a = 4'($urandom_range(0, 3));
      rq.addr_b = 4'($urandom_range(0, 3));
    end
    return rq;
  endfunction

  // wait before the next transfer; every fourth stretch runs back to back
  function automatic int unsigned draw_wait(input int unsigned n);
    if ((n / 97) % 4 == 3) return 0;
    return $urandom_range(0, MaxWait);
  endfunction

  // acceptance, prediction, checking and watchdog
  always @(posedge clk) begin
    rsp_t got, want;
    string bad;
    if (rst) begin
      req_taken   <= 1'b0;
      rsp_taken   <= 1'b0;
      idle_cycles = 0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      rsp_taken <= rsp_ch.valid && rsp_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(slice_predict(req_ch.data));
        reqs_acc++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        rsps_acc++;
        if (expected_rsps.size() == 0) begin
          if (mismatch_cnt < ReportMax) $display("unexpected result: %p", got);
          mismatch_cnt++;
        end else begin
          want = expected_rsps.pop_front();
          bad  = field_diff(want, got);
          if (bad != "") begin
            if (mismatch_cnt < ReportMax)
              $display("mismatch in%s: expected %p, got %p", bad, want, got);
            mismatch_cnt++;
          end
        end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!(req_ch.valid && !req_taken)) begin
        if (req_taken) gap_left = draw_wait(reqs_acc);
        if (gap_left > 0 || pending_reqs.size() == 0) begin
          if (gap_left > 0) gap_left--;
          req_ch.valid <= 1'b0;
        end else begin
          req_ch.data  <= pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
        end
      end
    end
  end

  // result sink with random back-pressure
  always @(negedge clk) begin
    if (!rst) begin
      if (rsp_taken) stall_left = draw_wait(rsps_acc + 50);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned total;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < RegCnt; i++) regfile_mdl[i] = '0;
    q_mdl = '0;

    // Q load, carry out with zero result, signed overflow, xor on D
    pending_reqs.push_back(make_req(DST_QREG, FN_OR, SRC_DZ, 4'h0, 4'h0, 4'hf, 1'b0, 4'h0));
    pending_reqs.push_back(make_req(DST_RAMF, FN_ADD, SRC_DZ, 4'h0, 4'hf, 4'hf, 1'b1, 4'hf));
    pending_reqs.push_back(make_req(DST_RAMF, FN_ADD, SRC_DZ, 4'h0, 4'h1, 4'h7, 1'b1, 4'h0));
    pending_reqs.push_back(make_req(DST_RAMF, FN_EXOR, SRC_DZ, 4'h0, 4'h2, 4'h5, 1'b0, 4'h0));
    // every source, function and destination, some with A and B at one address
    for (int i = 0; i < 8; i++) begin
      pending_reqs.push_back(make_req(dst_t'(3'(i)), fn_t'(3'(i)), src_t'(3'(i)),
                                      4'(i % 4), 4'((i % 2 == 0) ? i % 4 : 3 - i % 4),
                                      4'(2 * i + 1), i[0], i[0] ? 4'hf : 4'h0));
      pending_reqs.push_back(make_req(dst_t'(3'(7 - i)), fn_t'(3'(i + 3)), src_t'(3'(i)),
                                      4'(15 - i), 4'(i), 4'(14 - 2 * i), ~i[0],
                                      i[0] ? 4'h5 : 4'ha));
    end
    // shifts with all shift-in bits high, at the top and bottom addresses
    pending_reqs.push_back(make_req(DST_RAMQU, FN_AND, SRC_AB, 4'hf, 4'hf, 4'h0, 1'b1, 4'hf));
    pending_reqs.push_back(make_req(DST_RAMQD, FN_EXNOR, SRC_DQ, 4'h0, 4'h0, 4'hf, 1'b0, 4'hf));

    for (int i = 0; i < RandCnt; i++) pending_reqs.push_back(rand_req());
    total = pending_reqs.size();

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    while (reqs_acc != total || expected_rsps.size() != 0) @(negedge clk);
    repeat (DrainCyc) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- four_bit_slice_alu_with_regfile.f -----
hw/rtl/bsa_pkg.sv
hw/rtl/bsa_if.sv
hw/rtl/bsa_ram.sv
hw/rtl/bsa_alu.sv
hw/rtl/four_bit_slice_alu_with_regfile.sv
dv/tb_top.sv
